// ===== hdl/gwc_pkg.sv =====
// Shared types and constants for the Geiger window CPM counter.
// No dependencies; used by the divider, the top level and the port checker.
package gwc_pkg;

    // Field and register widths
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int PCT_W     = 7;
    localparam int M_DATA_W  = 80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONV      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV0       = 3'd2;

    // Input kinds carried in tuser
    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Arithmetic constants
    localparam int DEN_W = 26;                          // 60e6 fits in 26 bits
    localparam logic [31:0] MS_PER_MIN   = 32'd60000;
    localparam logic [31:0] US_PER_MIN   = 32'd60000000;
    localparam logic [31:0] PCT_SCALE    = 32'd100;
    localparam logic [31:0] DOSE_SCALE   = 32'd1000;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [31:0] U32_MAX      = 32'hFFFF_FFFF;

    // Shared divider: 64-bit dividend, 32-bit divisor, one quotient bit a cycle
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } gwc_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } gwc_div_rsp_t;

endpackage

// ===== hdl/gwc_div.sv =====
// Iterative restoring divider shared by all conversions of the counter.
// Depends on gwc_pkg for widths and the request/response structs.
module gwc_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gwc_pkg::gwc_div_req_t req,
    output gwc_pkg::gwc_div_rsp_t rsp
);
    import gwc_pkg::*;

    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]     rem_shift;
    logic                 ge;
    logic [DIV_D_W:0]     diff;

    // One restoring step: shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIV_N_W-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        diff      = rem_shift - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                quo_reg <= req.dividend;
                dvs_reg <= req.divisor;
                rem_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                rem_reg <= ge ? diff[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/geiger_window_cpm_counter.sv =====
// Geiger tube pulse counter with several gate windows and dead-time correction.
// A pulse item (tuser 0) bumps every window's count. A tick item (tuser 1)
// runs each window in turn through one shared 32x32 multiplier and one
// shared 64-bit bit-serial divider; when the correction denominator is not
// positive the real and dose divisions are skipped. The input is not ready
// during a tick, which also lasts through any stall on the result side.
// Results leave through an output register; one result per window per tick,
// tlast on the last window. Depends on gwc_pkg and gwc_div.
module geiger_window_cpm_counter #(
    parameter int NUM_WINDOWS = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gwc_pkg::TIME_W-1:0]         s_tdata,   // time_ms
    input  logic                               s_tuser,   // req_type
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // window[1:0], converted[2], real_cpm[34:3], dose_rate[66:35],
    // overflow[67], progress_pct[74:68], zero fill[79:75]
    output logic [gwc_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast,   // last
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gwc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gwc_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import gwc_pkg::*;

    localparam int WIN_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_TEST      = 4'd1;
    localparam logic [3:0] S_CPM_GO    = 4'd2;
    localparam logic [3:0] S_CPM_WAIT  = 4'd3;
    localparam logic [3:0] S_PCT_MUL   = 4'd4;
    localparam logic [3:0] S_PCT_GO    = 4'd5;
    localparam logic [3:0] S_PCT_WAIT  = 4'd6;
    localparam logic [3:0] S_DEN_MUL   = 4'd7;
    localparam logic [3:0] S_DEN_CHK   = 4'd8;
    localparam logic [3:0] S_REAL_GO   = 4'd9;
    localparam logic [3:0] S_REAL_WAIT = 4'd10;
    localparam logic [3:0] S_DOSE_MUL  = 4'd11;
    localparam logic [3:0] S_DOSE_GO   = 4'd12;
    localparam logic [3:0] S_DOSE_WAIT = 4'd13;
    localparam logic [3:0] S_OUT       = 4'd14;

    // Configuration
    logic [15:0]       dead_time_reg;
    logic [15:0]       conv_factor_reg;
    logic [TIME_W-1:0] interval_reg [NUM_WINDOWS];

    // Window state
    logic [CNT_W-1:0]  count_reg [NUM_WINDOWS];
    logic [TIME_W-1:0] last_ms_reg [NUM_WINDOWS];
    logic [31:0]       cpm_reg [NUM_WINDOWS];

    // Sequencer and work registers
    logic [3:0]        state_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [TIME_W-1:0] now_reg;
    logic [63:0]       prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              converted_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [31:0]       real_reg;
    logic [31:0]       dose_reg;
    logic              ovf_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;

    gwc_div_req_t div_req;
    gwc_div_rsp_t div_rsp;

    logic [TIME_W-1:0] iv;
    logic [15:0]       conv_eff;
    logic              elapsed;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [31:0]       quo_sat;
    logic              quo_big;
    logic              s_acc;
    logic              out_free;
    logic              last_win;

    // Effective interval and factor: zero acts as one
    always_comb begin
        iv       = (interval_reg[win_reg] == '0) ? TIME_W'(1) : interval_reg[win_reg];
        conv_eff = (conv_factor_reg == '0) ? 16'd1 : conv_factor_reg;
        elapsed  = {1'b0, now_reg} >= ({1'b0, last_ms_reg[win_reg]} + {1'b0, iv});
        quo_big  = |div_rsp.quotient[63:32];
        quo_sat  = quo_big ? U32_MAX : div_rsp.quotient[31:0];
        s_acc    = s_tvalid && s_tready;
        out_free = !m_tvalid_reg || m_tready;
        last_win = win_reg == WIN_W'(NUM_WINDOWS - 1);
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            S_TEST: begin
                mul_a = count_reg[win_reg];
                mul_b = MS_PER_MIN;
            end
            S_PCT_MUL: begin
                mul_a = now_reg - last_ms_reg[win_reg];
                mul_b = PCT_SCALE;
            end
            S_DEN_MUL: begin
                mul_a = cpm_reg[win_reg];
                mul_b = {16'd0, dead_time_reg};
            end
            S_DEN_CHK: begin
                mul_a = cpm_reg[win_reg];
                mul_b = US_PER_MIN;
            end
            S_DOSE_MUL: begin
                mul_a = real_reg;
                mul_b = DOSE_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared divider operand select
    always_comb begin
        div_req.dividend = prod_reg;
        unique case (state_reg)
            S_CPM_GO, S_PCT_GO: div_req.divisor = iv;
            S_REAL_GO:          div_req.divisor = DIV_D_W'(den_reg);
            S_DOSE_GO:          div_req.divisor = DIV_D_W'(conv_eff);
            default:            div_req.divisor = iv;
        endcase
        div_req.start = (state_reg == S_CPM_GO) || (state_reg == S_PCT_GO) ||
                        (state_reg == S_REAL_GO) || (state_reg == S_DOSE_GO);
    end

    gwc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_time_reg   <= 16'd0;
            conv_factor_reg <= 16'd1;
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                interval_reg[i] <= MS_PER_MIN;
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_DEAD_TIME) begin
                dead_time_reg <= cfg_data[15:0];
            end
            if (cfg_index == REG_CONV) begin
                conv_factor_reg <= cfg_data[15:0];
            end
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                if (cfg_index == CFG_IDX_W'(REG_IV0 + i)) begin
                    interval_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            win_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                count_reg[i]   <= '0;
                last_ms_reg[i] <= '0;
                cpm_reg[i]     <= '0;
            end
        end else begin
            // Output valid: set on a handoff, cleared once the item is taken
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser == REQ_TICK) begin
                            now_reg   <= s_tdata;
                            win_reg   <= '0;
                            state_reg <= S_TEST;
                        end else begin
                            for (int i = 0; i < NUM_WINDOWS; i++) begin
                                if (count_reg[i] != U32_MAX) begin
                                    count_reg[i] <= count_reg[i] + 1'b1;
                                end
                            end
                        end
                    end
                end
                S_TEST: begin
                    converted_reg <= elapsed;
                    ovf_reg       <= 1'b0;
                    prod_reg      <= mul_a * mul_b;
                    state_reg     <= elapsed ? S_CPM_GO : S_PCT_MUL;
                end
                S_CPM_GO:   state_reg <= S_CPM_WAIT;
                S_CPM_WAIT: begin
                    if (div_rsp.done) begin
                        cpm_reg[win_reg]     <= quo_sat;
                        count_reg[win_reg]   <= '0;
                        last_ms_reg[win_reg] <= now_reg;
                        state_reg            <= S_PCT_MUL;
                    end
                end
                S_PCT_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_PCT_GO;
                end
                S_PCT_GO:   state_reg <= S_PCT_WAIT;
                S_PCT_WAIT: begin
                    if (div_rsp.done) begin
                        pct_reg   <= (quo_big || quo_sat > 32'(PCT_MAX)) ?
                                     PCT_MAX : quo_sat[PCT_W-1:0];
                        state_reg <= S_DEN_MUL;
                    end
                end
                S_DEN_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_DEN_CHK;
                end
                // Denominator not positive: saturate both results; otherwise latch it and go on to the real division
                S_DEN_CHK: begin
                    if (prod_reg >= 64'(US_PER_MIN)) begin
                        real_reg  <= U32_MAX;
                        dose_reg  <= U32_MAX;
                        ovf_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        den_reg   <= US_PER_MIN[DEN_W-1:0] - prod_reg[DEN_W-1:0];
                        prod_reg  <= mul_a * mul_b;
                        state_reg <= S_REAL_GO;
                    end
                end
                S_REAL_GO:   state_reg <= S_REAL_WAIT;
                S_REAL_WAIT: begin
                    if (div_rsp.done) begin
                        real_reg  <= quo_sat;
                        ovf_reg   <= quo_big;
                        state_reg <= S_DOSE_MUL;
                    end
                end
                S_DOSE_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_DOSE_GO;
                end
                S_DOSE_GO:   state_reg <= S_DOSE_WAIT;
                S_DOSE_WAIT: begin
                    if (div_rsp.done) begin
                        dose_reg  <= quo_sat;
                        ovf_reg   <= ovf_reg | quo_big;
                        state_reg <= S_OUT;
                    end
                end
                // Hand the result to the output register once it is free
                S_OUT: begin
                    if (out_free) begin
                        m_tlast_reg  <= last_win;
                        m_tdata_reg  <= {5'd0, pct_reg, ovf_reg, dose_reg, real_reg,
                                         converted_reg, 2'(win_reg)};
                        if (last_win) begin
                            state_reg <= S_IDLE;
                        end else begin
                            win_reg   <= win_reg + 1'b1;
                            state_reg <= S_TEST;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

endmodule

// ===== hdl/gwc_checker.sv =====
// Port-level checks for the Geiger window CPM counter, bound to the top level.
// Depends on gwc_pkg; sees only the top-level ports.
module gwc_checker #(
    parameter int NUM_WINDOWS = 4
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [gwc_pkg::M_DATA_W-1:0]       m_tdata,
    input logic                               m_tlast
);
    import gwc_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // A tick keeps the input closed while windows are worked
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_TICK) |=> !s_tready)
        else $error("input open right after a tick item");

    // A pulse creates no result
    a_pulse_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_PULSE) && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a pulse item");

    // tlast only ever comes with the final window's result
    a_last_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[1:0] == 2'(NUM_WINDOWS - 1))
        else $error("tlast on a result that is not the final window");

    // Progress never exceeds one full interval
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[74:68] <= PCT_MAX)
        else $error("progress above one hundred percent");

endmodule

bind geiger_window_cpm_counter gwc_checker #(.NUM_WINDOWS(NUM_WINDOWS)) u_gwc_checker (.*);

// ===== sim/gwc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the Geiger window CPM counter: watches the config, input and
// result channels, predicts each window's result items and compares them. Depends on gwc_pkg.
module gwc_result_checker #(
    parameter int NUM_WINDOWS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gwc_pkg::TIME_W-1:0]     s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [gwc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [gwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gwc_pkg::CFG_DAT_W-1:0]  cfg_data,
    output int                             fail_count,
    output int                             results_owed
);
    import gwc_pkg::*;

    typedef struct {
        logic [1:0]       window;
        logic             converted;
        logic [31:0]      real_cpm;
        logic [31:0]      dose_rate;
        logic             overflow;
        logic [PCT_W-1:0] progress_pct;
        logic             last_win;
    } cpm_result_t;

    // Shadow of the block's registers and window state
    logic [15:0] dead_time_us;
    logic [15:0] conv_factor;
    logic [31:0] interval_ms  [NUM_WINDOWS];
    logic [31:0] pulse_cnt    [NUM_WINDOWS];
    logic [31:0] last_conv_ms [NUM_WINDOWS];
    logic [31:0] window_cpm   [NUM_WINDOWS];

    cpm_result_t owed_results [$];

    // Dead-time correction and dose; saturates and flags on overflow
    function automatic void apply_dead_time(input logic [31:0] cpm, output logic [31:0] real_c,
                                            output logic [31:0] dose, output logic ovf);
        logic [63:0] lost;
        longint      denom;
        logic [63:0] corr;
        logic [63:0] dose_w;
        logic [63:0] conv;
        lost  = 64'(cpm) * 64'(dead_time_us);
        denom = longint'(64'(US_PER_MIN)) - longint'(lost);
        conv  = (conv_factor == '0) ? 64'd1 : 64'(conv_factor);
        ovf   = 1'b0;
        if (denom <= 0) begin
            real_c = U32_MAX;
            dose   = U32_MAX;
            ovf    = 1'b1;
        end else begin
            corr = (64'(cpm) * 64'(US_PER_MIN)) / $unsigned(denom);
            if (corr > 64'(U32_MAX)) begin
                corr = 64'(U32_MAX);
                ovf  = 1'b1;
            end
            dose_w = (corr * 64'(DOSE_SCALE)) / conv;
            if (dose_w > 64'(U32_MAX)) begin
                dose_w = 64'(U32_MAX);
                ovf    = 1'b1;
            end
            real_c = corr[31:0];
            dose   = dose_w[31:0];
        end
    endfunction

    // A tick: convert elapsed windows, then one result per window
    task automatic predict_tick(input logic [31:0] now);
        logic [63:0] iv;
        logic [63:0] raw;
        logic [63:0] pct;
        logic [31:0] gone;
        logic [31:0] real_c;
        logic [31:0] dose;
        logic        ovf;
        logic        conv_now;
        cpm_result_t res;
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            iv       = (interval_ms[w] == '0) ? 64'd1 : 64'(interval_ms[w]);
            conv_now = 1'b0;
            // elapsed test without wrap
            if (64'(now) >= 64'(last_conv_ms[w]) + iv) begin
                raw             = (64'(pulse_cnt[w]) * 64'(MS_PER_MIN)) / iv;
                window_cpm[w]   = (raw > 64'(U32_MAX)) ? U32_MAX : raw[31:0];
                pulse_cnt[w]    = '0;
                last_conv_ms[w] = now;
                conv_now        = 1'b1;
            end
            gone = now - last_conv_ms[w];
            pct  = (64'(gone) * 64'(PCT_SCALE)) / iv;
            if (pct > 64'(PCT_MAX))
                pct = 64'(PCT_MAX);
            apply_dead_time(window_cpm[w], real_c, dose, ovf);
            res.window       = 2'(w);
            res.converted    = conv_now;
            res.real_cpm     = real_c;
            res.dose_rate    = dose;
            res.overflow     = ovf;
            res.progress_pct = pct[PCT_W-1:0];
            res.last_win     = (w == NUM_WINDOWS - 1);
            owed_results.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Everything is sampled at the rising edge, before any driver updates land
    always @(posedge aclk) begin
        cpm_result_t want;
        if (!aresetn) begin
            dead_time_us = '0;
            conv_factor  = 16'd1;
            for (int w = 0; w < NUM_WINDOWS; w++) begin
                interval_ms[w]  = MS_PER_MIN;
                pulse_cnt[w]    = '0;
                last_conv_ms[w] = '0;
                window_cpm[w]   = '0;
            end
            owed_results.delete();
        end else begin
            // register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DEAD_TIME)
                    dead_time_us = cfg_data[15:0];
                else if (cfg_index == REG_CONV)
                    conv_factor = cfg_data[15:0];
                else if (cfg_index >= REG_IV0 && 32'(cfg_index - REG_IV0) < NUM_WINDOWS)
                    interval_ms[cfg_index - REG_IV0] = cfg_data;
            end

            // input items
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_PULSE) begin
                    for (int w = 0; w < NUM_WINDOWS; w++)
                        if (pulse_cnt[w] != U32_MAX)
                            pulse_cnt[w]++;
                end else begin
                    predict_tick(s_tdata);
                end
            end

            // result items against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result item with nothing expected: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("window",       32'(want.window),       32'(m_tdata[1:0]));
                    check_field("converted",    32'(want.converted),    32'(m_tdata[2]));
                    check_field("real_cpm",     want.real_cpm,          m_tdata[34:3]);
                    check_field("dose_rate",    want.dose_rate,         m_tdata[66:35]);
                    check_field("overflow",     32'(want.overflow),     32'(m_tdata[67]));
                    check_field("progress_pct", 32'(want.progress_pct), 32'(m_tdata[74:68]));
                    check_field("last",         32'(want.last_win),     32'(m_tlast));
                end
            end
        end
        results_owed <= owed_results.size();
    end

endmodule

// ===== sim/tb_geiger_window_cpm_counter.sv =====
`timescale 1ns / 100ps
// Top of the Geiger window CPM counter testbench: clock, reset, stimulus and verdict.
// Depends on gwc_pkg, geiger_window_cpm_counter and gwc_result_checker.
module tb_geiger_window_cpm_counter;
    import gwc_pkg::*;

    localparam int WIN_COUNT     = 4;
    localparam int PHASE_ITEMS   = 20;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 3000;
    // 111 pulses at 9 us dead time put the 1 ms window just short of a zero denominator
    localparam int BURST_PULSES  = 111;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_FEED, IDLE_DRAIN, IDLE_BOTH} idle_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [TIME_W-1:0]    s_tdata   = '0;
    logic                 s_tuser   = REQ_PULSE;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_ready;

    int          fail_count;
    int          results_owed;
    int          feed_gap_pct   = 0;
    int          drain_stall_pct = 0;
    bit          hold_req       = 1'b0;
    logic [31:0] tube_ms;
    logic [31:0] gate_ms [WIN_COUNT];

    geiger_window_cpm_counter #(.NUM_WINDOWS(WIN_COUNT)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gwc_result_checker #(.NUM_WINDOWS(WIN_COUNT)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Run limit: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                repeat (HOLD_CYCLES) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= ($urandom_range(99) >= drain_stall_pct);
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                feed_gap_pct    = 0;
                drain_stall_pct = 0;
            end
            IDLE_FEED: begin
                feed_gap_pct    = 70;
                drain_stall_pct = 0;
            end
            IDLE_DRAIN: begin
                feed_gap_pct    = 0;
                drain_stall_pct = 70;
            end
            default: begin
                feed_gap_pct    = 27;
                drain_stall_pct = 27;
            end
        endcase
    endtask

    // One input item; valid stays up afterwards so items can go back to back
    task automatic send_item(input logic kind, input logic [31:0] t_ms);
        while ($urandom_range(99) < feed_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= t_ms;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Drain: stop sending, wait for every predicted result, then let the block go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // All registers, intervals from gate_ms, plus writes to unused indexes
    task automatic load_config(input logic [15:0] dead_us, input logic [15:0] conv);
        write_reg(REG_DEAD_TIME, {16'($urandom_range(16'hFFFF)), dead_us});
        write_reg(REG_CONV, {16'($urandom_range(16'hFFFF)), conv});
        for (int w = 0; w < WIN_COUNT; w++)
            write_reg(REG_IV0 + CFG_IDX_W'(w), gate_ms[w]);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1;
            default: return $urandom_range(40, 2);
        endcase
    endfunction

    initial begin
        int          left;
        logic [15:0] dead_us;
        logic [15:0] conv;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(IDLE_NONE);

        // Reset settings: idle window, pulses, half interval, conversion, stale time
        send_item(REQ_TICK, 32'd0);
        send_item(REQ_PULSE, 32'hFFFF_FFFF);
        send_item(REQ_PULSE, 32'd0);
        send_item(REQ_PULSE, 32'hA5A5_5A5A);
        send_item(REQ_TICK, 32'd30000);
        send_item(REQ_TICK, 32'd60000);
        send_item(REQ_TICK, 32'd59999);
        settle();

        // Max dead time (denominator negative), zero factor and zero/max intervals
        gate_ms = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7};
        load_config(16'hFFFF, 16'd0);
        repeat (3) send_item(REQ_PULSE, $urandom);
        send_item(REQ_TICK, 32'd60001);
        send_item(REQ_TICK, 32'd60007);
        settle();

        // No dead time, largest factor
        gate_ms = '{32'd1, 32'd2, 32'd60000, 32'd100};
        load_config(16'd0, 16'hFFFF);
        repeat (4) send_item(REQ_PULSE, $urandom);
        send_item(REQ_TICK, 32'd60010);
        settle();

        // Moderate correction with a positive denominator
        gate_ms = '{32'd1, 32'd1, 32'd1, 32'd1};
        load_config(16'd100, 16'd1);
        repeat (2) send_item(REQ_PULSE, $urandom);
        send_item(REQ_TICK, 32'd60011);
        tube_ms = 32'd60011;

        // Random phases: pulses then a tick with advancing time, some stale ticks
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            set_idling(idle_mode_t'(ph % 4));
            if (ph == 0) begin
                dead_us = 16'd0;
                conv    = 16'd1;
                gate_ms = '{32'd1, 32'd1, 32'd1, 32'd1};
            end else if (ph == 1) begin
                dead_us = 16'hFFFF;
                conv    = 16'hFFFF;
                gate_ms = '{32'd0, 32'd40, 32'hFFFF_FFFF, 32'd3};
            end else begin
                dead_us = 16'($urandom_range(1) ? $urandom_range(400)
                                                : $urandom_range(16'hFFFF));
                conv    = 16'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                       : $urandom_range(50, 1));
                for (int w = 0; w < WIN_COUNT; w++)
                    gate_ms[w] = pick_interval();
            end
            load_config(dead_us, conv);
            // big forward jump so the time field sweeps its upper bits over the run
            tube_ms += $urandom_range(32'h1800_0000, 32'h1000_0000);
            left = PHASE_ITEMS;
            while (left > 0) begin
                repeat ($urandom_range(3)) begin
                    if (left > 1) begin
                        send_item(REQ_PULSE, $urandom);
                        left--;
                    end
                end
                if ($urandom_range(9) == 0) begin
                    send_item(REQ_TICK, tube_ms - $urandom_range(5000, 1));
                end else begin
                    tube_ms += $urandom_range(30);
                    send_item(REQ_TICK, tube_ms);
                end
                left--;
            end
        end

        // Backpressure: result side held off while ticks keep coming
        settle();
        set_idling(IDLE_NONE);
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_item(REQ_PULSE, $urandom);
            tube_ms += 5;
            send_item(REQ_TICK, tube_ms);
        end

        // Pulse burst: corrected CPM saturates on the fastest window, dose on the next
        settle();
        gate_ms = '{32'd1, 32'd2, 32'd3, 32'd60000};
        load_config(16'd9, 16'd1);
        tube_ms += 100;
        send_item(REQ_TICK, tube_ms);
        repeat (BURST_PULSES) send_item(REQ_PULSE, $urandom);
        tube_ms += 3;
        send_item(REQ_TICK, tube_ms);

        // Largest time value
        send_item(REQ_TICK, 32'hFFFF_FFFF);

        settle();
        if (fail_count == 0 && results_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
